/* hdl/rgb_led_gamma_frame_packer_core_defines.svh */
// Assertion macros shared by the frame packer RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef RGB_LED_GAMMA_FRAME_PACKER_CORE_DEFINES_SVH
`define RGB_LED_GAMMA_FRAME_PACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GFLP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame packer check failed");

// Next-cycle implication under reset.
`define GFLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame packer check failed");

`endif

/* hdl/gflp_pkg.sv */
// Shared types, codes and ROM contents for the LED frame packer.
// No dependencies.
`default_nettype none

package gflp_pkg;

  localparam logic ACT_SET  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [7:0] SLOT_UNUSED = 8'd255;
  localparam int unsigned MAP_ENTRIES = 120;
  localparam int unsigned POS_W = 10;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SET_RD,
    S_SET_WR,
    S_GET_RD,
    S_GET_CAP,
    S_GET_OUT
  } gflp_state_t;

  typedef struct packed {
    logic clear;
    logic wr_full;
    logic wr_merge;
    logic odd;
  } gflp_lane_ctl_t;

  localparam logic [11:0] GAMMA_ROM [256] = '{
    12'h000, 12'h00A, 12'h014, 12'h01E, 12'h028, 12'h033, 12'h03D, 12'h047,
    12'h051, 12'h05C, 12'h066, 12'h071, 12'h07B, 12'h086, 12'h090, 12'h09B,
    12'h0A5, 12'h0B0, 12'h0BA, 12'h0C5, 12'h0D0, 12'h0DB, 12'h0E5, 12'h0F0,
    12'h0FB, 12'h106, 12'h111, 12'h11C, 12'h127, 12'h132, 12'h13D, 12'h148,
    12'h154, 12'h15F, 12'h16A, 12'h175, 12'h181, 12'h18C, 12'h198, 12'h1A3,
    12'h1AF, 12'h1BA, 12'h1C6, 12'h1D1, 12'h1DD, 12'h1E9, 12'h1F4, 12'h200,
    12'h20C, 12'h218, 12'h224, 12'h230, 12'h23C, 12'h248, 12'h254, 12'h260,
    12'h26C, 12'h278, 12'h284, 12'h291, 12'h29D, 12'h2A9, 12'h2B6, 12'h2C2,
    12'h2CF, 12'h2DB, 12'h2E8, 12'h2F4, 12'h301, 12'h30E, 12'h31B, 12'h327,
    12'h334, 12'h341, 12'h34E, 12'h35B, 12'h368, 12'h375, 12'h382, 12'h38F,
    12'h39D, 12'h3AA, 12'h3B7, 12'h3C4, 12'h3D2, 12'h3DF, 12'h3ED, 12'h3FA,
    12'h408, 12'h415, 12'h423, 12'h431, 12'h43E, 12'h44C, 12'h45A, 12'h468,
    12'h476, 12'h484, 12'h492, 12'h4A0, 12'h4AE, 12'h4BC, 12'h4CB, 12'h4D9,
    12'h4E7, 12'h4F6, 12'h504, 12'h512, 12'h521, 12'h530, 12'h53E, 12'h54D,
    12'h55C, 12'h56A, 12'h579, 12'h588, 12'h597, 12'h5A6, 12'h5B5, 12'h5C4,
    12'h5D3, 12'h5E2, 12'h5F2, 12'h601, 12'h610, 12'h620, 12'h62F, 12'h63F,
    12'h64E, 12'h65E, 12'h66D, 12'h67D, 12'h68D, 12'h69D, 12'h6AD, 12'h6BD,
    12'h6CD, 12'h6DD, 12'h6ED, 12'h6FD, 12'h70D, 12'h71D, 12'h72E, 12'h73E,
    12'h74E, 12'h75F, 12'h770, 12'h780, 12'h791, 12'h7A2, 12'h7B2, 12'h7C3,
    12'h7D4, 12'h7E5, 12'h7F6, 12'h807, 12'h818, 12'h829, 12'h83B, 12'h84C,
    12'h85D, 12'h86F, 12'h880, 12'h892, 12'h8A3, 12'h8B5, 12'h8C7, 12'h8D9,
    12'h8EA, 12'h8FC, 12'h90E, 12'h920, 12'h932, 12'h945, 12'h957, 12'h969,
    12'h97B, 12'h98E, 12'h9A0, 12'h9B3, 12'h9C5, 12'h9D8, 12'h9EB, 12'h9FE,
    12'hA10, 12'hA23, 12'hA36, 12'hA49, 12'hA5C, 12'hA70, 12'hA83, 12'hA96,
    12'hAAA, 12'hABD, 12'hAD1, 12'hAE4, 12'hAF8, 12'hB0C, 12'hB1F, 12'hB33,
    12'hB47, 12'hB5B, 12'hB6F, 12'hB83, 12'hB97, 12'hBAC, 12'hBC0, 12'hBD4,
    12'hBE9, 12'hBFD, 12'hC12, 12'hC27, 12'hC3C, 12'hC50, 12'hC65, 12'hC7A,
    12'hC8F, 12'hCA4, 12'hCBA, 12'hCCF, 12'hCE4, 12'hCFA, 12'hD0F, 12'hD25,
    12'hD3A, 12'hD50, 12'hD66, 12'hD7C, 12'hD92, 12'hDA8, 12'hDBE, 12'hDD4,
    12'hDEA, 12'hE00, 12'hE17, 12'hE2D, 12'hE44, 12'hE5A, 12'hE71, 12'hE88,
    12'hE9F, 12'hEB6, 12'hECD, 12'hEE4, 12'hEFB, 12'hF12, 12'hF29, 12'hF41,
    12'hF58, 12'hF70, 12'hF88, 12'hF9F, 12'hFB7, 12'hFCF, 12'hFE7, 12'hFFF
  };

  localparam logic [7:0] SLOT_ROM [MAP_ENTRIES] = '{
    8'd23, 8'd22, 8'd21, 8'd20, 8'd19, 8'd18, 8'd17, 8'd16, 8'd15, 8'd14, 8'd13, 8'd12,
    8'd11, 8'd10, 8'd9, 8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0,
    8'd47, 8'd46, 8'd45, 8'd44, 8'd43, 8'd42, 8'd41, 8'd40, 8'd39, 8'd38, 8'd37, 8'd36,
    8'd35, 8'd34, 8'd33, 8'd32, 8'd31, 8'd30, 8'd29, 8'd28, 8'd27, 8'd26, 8'd25, 8'd24,
    8'd71, 8'd70, 8'd69, 8'd68, 8'd67, 8'd66, 8'd65, 8'd64, 8'd63, 8'd62, 8'd61, 8'd60,
    8'd59, 8'd58, 8'd57, 8'd56, 8'd55, 8'd54, 8'd53, 8'd52, 8'd51, 8'd50, 8'd49, 8'd48,
    8'd95, 8'd94, 8'd93, 8'd92, 8'd91, 8'd90, 8'd89, 8'd88, 8'd87, 8'd86, 8'd85, 8'd84,
    8'd83, 8'd82, 8'd81, 8'd80, 8'd79, 8'd78, 8'd77, 8'd76, 8'd75, 8'd74, 8'd73, 8'd72,
    8'd119, 8'd118, 8'd117, 8'd116, 8'd115, 8'd114, 8'd113, 8'd112, 8'd111, 8'd110,
    8'd109, 8'd108,
    8'd107, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255
  };

  // Board map; indexes past the table read as unused.
  function automatic logic [7:0] slot_of(input logic [6:0] idx);
    logic [7:0] s;
    s = SLOT_UNUSED;
    if (int'(idx) < MAP_ENTRIES) begin
      s = SLOT_ROM[idx];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* hdl/gflp_ifs.sv */
// Valid/ready channel interfaces for the LED frame packer.
// No dependencies.
`default_nettype none

interface gflp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [6:0] led_index;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;
  logic [7:0] byte_address;

  modport source (output valid, action, led_index, red_level, green_level, blue_level,
                  byte_address, input ready);
  modport sink (input valid, action, led_index, red_level, green_level, blue_level,
                byte_address, output ready);
endinterface

interface gflp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_byte;
  logic [7:0] green_byte;
  logic [7:0] blue_byte;

  modport source (output valid, red_byte, green_byte, blue_byte, input ready);
  modport sink (input valid, red_byte, green_byte, blue_byte, output ready);
endinterface

`default_nettype wire

/* hdl/gflp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gflp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 180
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/gflp_lane.sv */
// One color lane: gamma lookup, 12-bit packing and its frame plane RAM.
// Depends on gflp_pkg and gflp_ram.
`default_nettype none

module gflp_lane #(
  parameter int FRAME_BYTES = 180,
  parameter int AW = 8
) (
  input  wire logic                   clk,
  input  gflp_pkg::gflp_lane_ctl_t    ctl,
  input  wire logic [AW-1:0]          addr_full,
  input  wire logic [AW-1:0]          addr_rmw,
  input  wire logic [7:0]             level,
  output logic      [7:0]             rd_data
);

  logic [11:0]   gval;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  assign gval  = gflp_pkg::GAMMA_ROM[level];
  assign we    = ctl.clear | ctl.wr_full | ctl.wr_merge;
  assign waddr = (ctl.clear || ctl.wr_full) ? addr_full : addr_rmw;

  // Zero during clear, else a full byte or a merge with the kept nibble of the byte read last cycle.
  always_comb begin
    if (ctl.clear) begin
      wdata = 8'h00;
    end else if (ctl.wr_full) begin
      wdata = ctl.odd ? gval[7:0] : gval[11:4];
    end else begin
      wdata = ctl.odd ? {rd_data[7:4], gval[11:8]} : {gval[3:0], rd_data[3:0]};
    end
  end

  gflp_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_plane (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr_rmw),
    .rdata (rd_data)
  );

endmodule

`default_nettype wire

/* hdl/rgb_led_gamma_frame_packer_core.sv */
// Set item: accepted, then plane access in S_SET_RD (read/full write) and S_SET_WR (merge write);
// next item accepted once back in S_IDLE after a set that writes, the cycle after an ignored set.
// Read item: result valid in S_GET_OUT after S_GET_RD and S_GET_CAP, held until the transfer; next item
// the cycle after. The planes are one RAM read port and one write port per color lane.
// After reset a clearing pass zeroes all FRAME_BYTES bytes of the planes, accepting nothing.
// Depends on gflp_pkg, gflp_ifs, gflp_lane and the assertion macro header.
`default_nettype none
`include "rgb_led_gamma_frame_packer_core_defines.svh"

module rgb_led_gamma_frame_packer_core #(
  parameter int FRAME_BYTES = 180,
  parameter int LED_SLOTS   = 120
) (
  input wire logic    clk,
  input wire logic    rst_n,
  gflp_in_if.sink     in_ch,
  gflp_out_if.source  out_ch
);

  localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int PW = gflp_pkg::POS_W;

  gflp_pkg::gflp_state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] full_addr_r, rmw_addr_r;
  logic          odd_r, oor_r;
  logic [7:0]    red_lvl_r, green_lvl_r, blue_lvl_r;
  logic [7:0]    red_byte_r, green_byte_r, blue_byte_r;

  logic          accept;
  logic [7:0]    slot;
  logic [PW-1:0] pos, pos_p1;
  logic          set_ok, rd_oor;
  logic [7:0]    red_rd, green_rd, blue_rd;
  logic [AW-1:0] lane_full_addr;
  gflp_pkg::gflp_lane_ctl_t lane_ctl;

  assign accept = in_ch.valid && in_ch.ready;

  // Start byte is 12*slot/8 = slot + slot/2.
  assign slot   = gflp_pkg::slot_of(in_ch.led_index);
  assign pos    = PW'({2'b00, slot}) + PW'({3'b000, slot[7:1]});
  assign pos_p1 = pos + PW'(1);
  assign set_ok = (PW'(in_ch.led_index) < PW'(LED_SLOTS)) &&
                  (slot != gflp_pkg::SLOT_UNUSED) &&
                  (pos_p1 < PW'(FRAME_BYTES));
  assign rd_oor = PW'(in_ch.byte_address) >= PW'(FRAME_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= gflp_pkg::S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == gflp_pkg::S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // Item capture and output register; payload only.
  always_ff @(posedge clk) begin
    if (accept) begin
      red_lvl_r   <= in_ch.red_level;
      green_lvl_r <= in_ch.green_level;
      blue_lvl_r  <= in_ch.blue_level;
      odd_r       <= slot[0];
      oor_r       <= rd_oor;
      if (in_ch.action == gflp_pkg::ACT_SET) begin
        full_addr_r <= slot[0] ? AW'(pos_p1) : AW'(pos);
        rmw_addr_r  <= slot[0] ? AW'(pos) : AW'(pos_p1);
      end else begin
        rmw_addr_r  <= AW'(in_ch.byte_address);
      end
    end
    if (state_r == gflp_pkg::S_GET_CAP) begin
      red_byte_r   <= oor_r ? 8'h00 : red_rd;
      green_byte_r <= oor_r ? 8'h00 : green_rd;
      blue_byte_r  <= oor_r ? 8'h00 : blue_rd;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gflp_pkg::S_CLEAR: begin
        if (clr_cnt_r == AW'(FRAME_BYTES - 1)) begin
          state_nxt = gflp_pkg::S_IDLE;
        end
      end
      gflp_pkg::S_IDLE: begin
        if (accept) begin
          if (in_ch.action == gflp_pkg::ACT_READ) begin
            state_nxt = gflp_pkg::S_GET_RD;
          end else if (set_ok) begin
            state_nxt = gflp_pkg::S_SET_RD;
          end
        end
      end
      gflp_pkg::S_SET_RD:  state_nxt = gflp_pkg::S_SET_WR;
      gflp_pkg::S_SET_WR:  state_nxt = gflp_pkg::S_IDLE;
      gflp_pkg::S_GET_RD:  state_nxt = gflp_pkg::S_GET_CAP;
      gflp_pkg::S_GET_CAP: state_nxt = gflp_pkg::S_GET_OUT;
      gflp_pkg::S_GET_OUT: begin
        if (out_ch.ready) begin
          state_nxt = gflp_pkg::S_IDLE;
        end
      end
      default: state_nxt = gflp_pkg::S_IDLE;
    endcase
  end

  assign in_ch.ready       = (state_r == gflp_pkg::S_IDLE);
  assign out_ch.valid      = (state_r == gflp_pkg::S_GET_OUT);
  assign out_ch.red_byte   = red_byte_r;
  assign out_ch.green_byte = green_byte_r;
  assign out_ch.blue_byte  = blue_byte_r;

  assign lane_ctl.clear    = (state_r == gflp_pkg::S_CLEAR);
  assign lane_ctl.wr_full  = (state_r == gflp_pkg::S_SET_RD);
  assign lane_ctl.wr_merge = (state_r == gflp_pkg::S_SET_WR);
  assign lane_ctl.odd      = odd_r;
  assign lane_full_addr    = lane_ctl.clear ? clr_cnt_r : full_addr_r;

  gflp_lane #(.FRAME_BYTES(FRAME_BYTES), .AW(AW)) u_red (
    .clk (clk), .ctl (lane_ctl), .addr_full (lane_full_addr), .addr_rmw (rmw_addr_r),
    .level (red_lvl_r), .rd_data (red_rd)
  );

  gflp_lane #(.FRAME_BYTES(FRAME_BYTES), .AW(AW)) u_green (
    .clk (clk), .ctl (lane_ctl), .addr_full (lane_full_addr), .addr_rmw (rmw_addr_r),
    .level (green_lvl_r), .rd_data (green_rd)
  );

  gflp_lane #(.FRAME_BYTES(FRAME_BYTES), .AW(AW)) u_blue (
    .clk (clk), .ctl (lane_ctl), .addr_full (lane_full_addr), .addr_rmw (rmw_addr_r),
    .level (blue_lvl_r), .rd_data (blue_rd)
  );

  `GFLP_ASSERT_NOW(a_no_accept_with_result, in_ch.ready, !out_ch.valid)
  `GFLP_ASSERT_NOW(a_no_accept_in_clear, state_r == gflp_pkg::S_CLEAR, !in_ch.ready)
  `GFLP_ASSERT_NEXT(a_merge_follows_full, state_r == gflp_pkg::S_SET_RD,
                    state_r == gflp_pkg::S_SET_WR)
  `GFLP_ASSERT_NEXT(a_result_after_capture, state_r == gflp_pkg::S_GET_CAP, out_ch.valid)

endmodule

`default_nettype wire

/* sim/rgb_led_gamma_frame_packer_core_test.sv */
// Self-checking test of the LED frame packer: a driver feeds set and read transfers,
// a shadow copy of the three planes predicts every read. Uses gflp_pkg and gflp_ifs.
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_gamma_frame_packer_core_test;

  localparam int FRAME_BYTES = 180;
  localparam int LED_SLOTS   = 120;

  typedef struct packed {
    logic       action;
    logic [6:0] led_index;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [7:0] byte_address;
  } led_cmd_t;

  typedef struct packed {
    logic [7:0] red_byte;
    logic [7:0] green_byte;
    logic [7:0] blue_byte;
  } pixel_bytes_t;

  logic clk;
  logic rst_n;

  gflp_in_if  in_ch ();
  gflp_out_if out_ch ();

  rgb_led_gamma_frame_packer_core #(
    .FRAME_BYTES(FRAME_BYTES),
    .LED_SLOTS(LED_SLOTS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  logic [7:0] shadow_red [FRAME_BYTES];
  logic [7:0] shadow_green [FRAME_BYTES];
  logic [7:0] shadow_blue [FRAME_BYTES];

  led_cmd_t     cmd_queue [$];
  pixel_bytes_t read_queue [$];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off;
  bit  stim_done;
  int  mismatch_count;
  int  reads_seen;
  int  sets_sent;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [7:0] pack_byte(input logic [7:0] old_byte, input logic odd,
                                           input logic first, input logic [11:0] v);
    logic [7:0] b;
    if (odd) begin
      b = first ? {old_byte[7:4], v[11:8]} : v[7:0];
    end else begin
      b = first ? v[11:4] : {v[3:0], old_byte[3:0]};
    end
    return b;
  endfunction

  // Update the shadow planes for one accepted transfer; queue the read result.
  task automatic apply_frame_cmd(input led_cmd_t c);
    logic [7:0] slot;
    int pos;
    pixel_bytes_t r;
    if (c.action == gflp_pkg::ACT_SET) begin
      sets_sent++;
      if (int'(c.led_index) >= LED_SLOTS ||
          int'(c.led_index) >= int'(gflp_pkg::MAP_ENTRIES)) return;
      slot = gflp_pkg::SLOT_ROM[c.led_index];
      if (slot == gflp_pkg::SLOT_UNUSED) return;
      pos = (int'(slot) * 12) / 8;
      if (pos + 1 >= FRAME_BYTES) return;
      for (int k = 0; k < 2; k++) begin
        shadow_red[pos+k] = pack_byte(shadow_red[pos+k], slot[0], k == 0,
                                      gflp_pkg::GAMMA_ROM[c.red_level]);
        shadow_green[pos+k] = pack_byte(shadow_green[pos+k], slot[0], k == 0,
                                        gflp_pkg::GAMMA_ROM[c.green_level]);
        shadow_blue[pos+k] = pack_byte(shadow_blue[pos+k], slot[0], k == 0,
                                       gflp_pkg::GAMMA_ROM[c.blue_level]);
      end
    end else begin
      r = '0;
      if (int'(c.byte_address) < FRAME_BYTES) begin
        r = {shadow_red[c.byte_address], shadow_green[c.byte_address],
             shadow_blue[c.byte_address]};
      end
      read_queue.push_back(r);
    end
  endtask

  function automatic led_cmd_t rand_cmd(input bit is_read);
    led_cmd_t c;
    c.action       = is_read ? gflp_pkg::ACT_READ : gflp_pkg::ACT_SET;
    c.led_index    = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(107, 127))
                                                 : 7'($urandom_range(0, 119));
    c.red_level    = 8'($urandom);
    c.green_level  = 8'($urandom);
    c.blue_level   = 8'($urandom);
    c.byte_address = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(180, 255))
                                                  : 8'($urandom_range(0, 179));
    return c;
  endfunction

  function automatic led_cmd_t make_cmd(input logic act, input int idx, input int r,
                                        input int g, input int b, input int addr);
    led_cmd_t c;
    c = {act, 7'(idx), 8'(r), 8'(g), 8'(b), 8'(addr)};
    return c;
  endfunction

  // Driver: hold the payload until the transfer, then advance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) apply_frame_cmd({in_ch.action, in_ch.led_index, in_ch.red_level,
                                        in_ch.green_level, in_ch.blue_level,
                                        in_ch.byte_address});
      if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        {in_ch.action, in_ch.led_index, in_ch.red_level, in_ch.green_level,
         in_ch.blue_level, in_ch.byte_address} <= cmd_queue.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest predicted read.
  always @(posedge clk) begin
    pixel_bytes_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        reads_seen++;
        if (read_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected read result %h %h %h",
                                             out_ch.red_byte, out_ch.green_byte,
                                             out_ch.blue_byte);
        end else begin
          want = read_queue.pop_front();
          if (out_ch.red_byte !== want.red_byte || out_ch.green_byte !== want.green_byte ||
              out_ch.blue_byte !== want.blue_byte) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("read mismatch: expected r=%h g=%h b=%h got r=%h g=%h b=%h",
                       want.red_byte, want.green_byte, want.blue_byte,
                       out_ch.red_byte, out_ch.green_byte, out_ch.blue_byte);
          end
        end
      end
      out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (cmd_queue.size() > 0 || in_ch.valid || read_queue.size() > 0) @(posedge clk);
  endtask

  initial begin
    int phase_idle [4] = '{0, 87, 0, 26};
    int phase_stall [4] = '{0, 0, 87, 26};
    in_ch.valid = 1'b0;
    in_ch.action = gflp_pkg::ACT_SET;
    in_ch.led_index = '0;
    in_ch.red_level = '0;
    in_ch.green_level = '0;
    in_ch.blue_level = '0;
    in_ch.byte_address = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    mismatch_count = 0;
    reads_seen = 0;
    sets_sent = 0;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      shadow_red[i] = '0;
      shadow_green[i] = '0;
      shadow_blue[i] = '0;
    end
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset contents, extremes, both slot parities, unused and out-of-range LEDs.
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_READ, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_READ, 0, 0, 0, 0, 179));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_SET, 23, 255, 0, 128, 0));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_SET, 22, 1, 255, 77, 0));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_READ, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_READ, 0, 0, 0, 0, 1));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_READ, 0, 0, 0, 0, 2));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_SET, 96, 255, 255, 255, 0));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_SET, 108, 170, 85, 255, 255));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_READ, 0, 0, 0, 0, 178));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_READ, 0, 0, 0, 0, 179));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_SET, 109, 255, 255, 255, 0));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_SET, 119, 255, 255, 255, 0));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_SET, 120, 255, 255, 255, 0));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_SET, 127, 255, 255, 255, 0));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_READ, 0, 0, 0, 0, 161));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_READ, 0, 0, 0, 0, 162));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_READ, 127, 255, 255, 255, 180));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_READ, 0, 0, 0, 0, 255));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_SET, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_READ, 0, 0, 0, 0, 34));
    cmd_queue.push_back(make_cmd(gflp_pkg::ACT_READ, 0, 0, 0, 0, 35));
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int i = 0; i < 230; i++) cmd_queue.push_back(rand_cmd($urandom_range(0, 1)));
      if (p == 0) begin
        // Back up the result side while reads keep coming.
        repeat (20) @(posedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_drained();
    end
    stim_done = 1'b1;
    repeat (20) @(posedge clk);
    $display("covered %0d set transfers and %0d read results over four idling phases",
             sets_sent, reads_seen);
    if (mismatch_count == 0 && read_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
